// ----- design/assert_macros.svh -----
// assertion macros shared by the converter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define HSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define HSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/hsl_pkg.sv -----
// shared types, constants and helper functions for the hsl to rgb converter
package hsl_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned REG_W     = 17;
  localparam int unsigned POS_W     = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_SAT_IDX   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_IDX = 8'd1;

  localparam logic [REG_W-1:0] SAT_RESET   = 17'd55706;
  localparam logic [REG_W-1:0] LIGHT_RESET = 17'd49152;
  localparam logic [REG_W-1:0] Q_ONE       = 17'd65536;
  localparam logic [REG_W-1:0] HALF_Q      = 17'd32768;

  localparam logic [POS_W-1:0] SIXTH6      = 19'd65536;
  localparam logic [POS_W-1:0] HALF_TURN6  = 19'd196608;
  localparam logic [POS_W-1:0] TWO_THIRDS6 = 19'd262144;
  localparam logic [POS_W-1:0] THIRD6      = 19'd131072;
  localparam logic [POS_W-1:0] TURN6       = 19'd393216;

  typedef struct packed {
    logic en3;
    logic en4;
  } hsl_chan_en_t;

  function automatic logic [REG_W-1:0] sat_clamp(input logic [REG_W-1:0] v);
    sat_clamp = (v > Q_ONE) ? Q_ONE : v;
  endfunction

  // slope factor of the hue ramp: v = p*65536 + (q-p)*m
  function automatic logic [REG_W-1:0] ramp_mult(input logic [POS_W-1:0] t6);
    logic [POS_W-1:0] fall;
    fall = TWO_THIRDS6 - t6;
    if (t6 < SIXTH6) begin
      ramp_mult = t6[REG_W-1:0];
    end else if (t6 < HALF_TURN6) begin
      ramp_mult = Q_ONE;
    end else if (t6 < TWO_THIRDS6) begin
      ramp_mult = fall[REG_W-1:0];
    end else begin
      ramp_mult = '0;
    end
  endfunction

  // add an offset below one turn and wrap modulo one turn
  function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic [POS_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, TURN6}) begin
      sum = sum - {1'b0, TURN6};
    end
    wrap_add = sum[POS_W-1:0];
  endfunction

endpackage

// ----- design/hsl_cfg.sv -----
// configuration registers for saturation and lightness
`include "assert_macros.svh"
module hsl_cfg
  import hsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output logic [REG_W-1:0]     sat_o,
  output logic [REG_W-1:0]     light_o
);

  logic [REG_W-1:0] sat_r;
  logic [REG_W-1:0] sat_nxt;
  logic [REG_W-1:0] light_r;
  logic [REG_W-1:0] light_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    sat_nxt   = sat_r;
    light_nxt = light_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SAT_IDX:   sat_nxt   = cfg_data;
        CFG_LIGHT_IDX: light_nxt = cfg_data;
        default: begin
          sat_nxt   = sat_r;
          light_nxt = light_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r   <= SAT_RESET;
      light_r <= LIGHT_RESET;
    end else begin
      sat_r   <= sat_nxt;
      light_r <= light_nxt;
    end
  end

  assign sat_o   = sat_clamp(sat_r);
  assign light_o = sat_clamp(light_r);

  `HSL_ASSERT_NEXT(a_sat_write, cfg_valid && cfg_ready && cfg_index == CFG_SAT_IDX, sat_r == $past(cfg_data), "saturation write lost")
  `HSL_ASSERT_NEXT(a_light_write, cfg_valid && cfg_ready && cfg_index == CFG_LIGHT_IDX, light_r == $past(cfg_data), "lightness write lost")
  `HSL_ASSERT_NEXT(a_bad_index, cfg_valid && cfg_index != CFG_SAT_IDX && cfg_index != CFG_LIGHT_IDX, $stable(sat_r) && $stable(light_r), "write to unknown index changed a register")

endmodule

// ----- design/hsl_chan.sv -----
// per-channel ramp evaluation and scaling to 8 bits, two pipeline stages
module hsl_chan
  import hsl_pkg::*;
(
  input  logic               clk,
  input  hsl_chan_en_t       en,
  input  logic [REG_W-1:0]   p_i,
  input  logic [REG_W:0]     d_i,
  input  logic [REG_W-1:0]   m_i,
  output logic [7:0]         chan_o
);

  logic [35:0] v_r;
  logic [35:0] v_nxt;
  logic [34:0] prod;
  logic [7:0]  chan_r;
  logic [7:0]  chan_nxt;
  logic [43:0] scaled;
  logic [11:0] whole;

  always_comb begin
    prod  = {17'd0, d_i} * {18'd0, m_i};
    v_nxt = {3'd0, p_i, 16'd0} + {1'b0, prod};
  end

  // floor(v*255 / 2^32) with clamp
  always_comb begin
    scaled = {v_r, 8'd0} - {8'd0, v_r};
    whole  = scaled[43:32];
    if (whole > 12'd255) begin
      chan_nxt = 8'hff;
    end else begin
      chan_nxt = whole[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      v_r <= v_nxt;
    end
    if (en.en4) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan_o = chan_r;

endmodule

// ----- design/hsl_to_rgb_converter.sv -----
// top level of the hsl to rgb converter: front stages and pipeline control
//
// usage:
//   in_valid/in_ready carry one hue beat (in_hue, a 16-bit fraction of a turn)
//   out_valid/out_ready carry one rgb beat (out_red, out_green, out_blue)
//   cfg_valid/cfg_ready write saturation (index 0) or lightness (index 1),
//   17-bit values where 65536 is full scale; larger values act as 65536;
//   cfg_ready is always high, write only while no beat is in flight
// timing:
//   four register stages; a hue accepted into stage one passes through stages
//   two and three and raises out_valid when it reaches stage four;
//   one beat per cycle sustained while out_ready stays high, with one
//   18x17 multiplier per channel in stage three
// reset:
//   rst_n low at a clock edge empties the pipeline and restores saturation
//   55706 and lightness 49152
// stalls:
//   while out_ready is low the output beat holds; each stage keeps taking
//   beats until it is full, then in_ready drops; nothing is lost or repeated
`include "assert_macros.svh"
module hsl_to_rgb_converter
  import hsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          in_hue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic [REG_W-1:0] sat;
  logic [REG_W-1:0] light;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  hsl_chan_en_t chan_en;

  // stage 1
  logic [POS_W-1:0] h6;
  logic [POS_W-1:0] t_red_r, t_grn_r, t_blu_r;
  logic [33:0]      prod_r;
  logic [REG_W-1:0] l1_r;
  logic [REG_W-1:0] s1_r;

  // stage 2
  logic [17:0]      ls_hi;
  logic [POS_W-1:0] q_raw;
  logic [POS_W-1:0] two_l;
  logic [POS_W-1:0] q_nxt;
  logic [POS_W-1:0] p_nxt;
  logic [POS_W-1:0] d_nxt;
  logic [REG_W:0]   q_r;
  logic [REG_W-1:0] p_r;
  logic [REG_W:0]   d_r;
  logic [REG_W-1:0] m_red_r, m_grn_r, m_blu_r;

  hsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sat_o     (sat),
    .light_o   (light)
  );

  // stall chain, bubbles collapse
  assign en4      = ~v4_r | out_ready;
  assign en3      = ~v3_r | en4;
  assign en2      = ~v2_r | en3;
  assign en1      = ~v1_r | en2;
  assign in_ready = en1;
  assign out_valid = v4_r;
  assign chan_en.en3 = en3;
  assign chan_en.en4 = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // hue positions in sixths of a turn
  assign h6 = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};

  always_ff @(posedge clk) begin
    if (en1) begin
      t_red_r <= wrap_add(h6, THIRD6);
      t_grn_r <= h6;
      t_blu_r <= wrap_add(h6, TURN6 - THIRD6);
      prod_r  <= light * sat;
      l1_r    <= light;
      s1_r    <= sat;
    end
  end

  // q and p
  always_comb begin
    ls_hi = prod_r[33:16];
    two_l = {1'b0, l1_r, 1'b0};
    if (l1_r < HALF_Q) begin
      q_raw = {2'b00, l1_r} + {1'b0, ls_hi};
    end else begin
      q_raw = {2'b00, l1_r} + {2'b00, s1_r} - {1'b0, ls_hi};
    end
    q_nxt = (q_raw > two_l) ? two_l : q_raw;
    if (q_nxt < {2'b00, l1_r}) begin
      q_nxt = {2'b00, l1_r};
    end
    p_nxt = two_l - q_nxt;
    d_nxt = q_nxt - p_nxt;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      q_r     <= q_nxt[REG_W:0];
      p_r     <= p_nxt[REG_W-1:0];
      d_r     <= d_nxt[REG_W:0];
      m_red_r <= ramp_mult(t_red_r);
      m_grn_r <= ramp_mult(t_grn_r);
      m_blu_r <= ramp_mult(t_blu_r);
    end
  end

  hsl_chan u_red (
    .clk    (clk),
    .en     (chan_en),
    .p_i    (p_r),
    .d_i    (d_r),
    .m_i    (m_red_r),
    .chan_o (out_red)
  );

  hsl_chan u_green (
    .clk    (clk),
    .en     (chan_en),
    .p_i    (p_r),
    .d_i    (d_r),
    .m_i    (m_grn_r),
    .chan_o (out_green)
  );

  hsl_chan u_blue (
    .clk    (clk),
    .en     (chan_en),
    .p_i    (p_r),
    .d_i    (d_r),
    .m_i    (m_blu_r),
    .chan_o (out_blue)
  );

  `HSL_ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready, "input stalled with empty output")
  `HSL_ASSERT_IMP(a_p_below_q, v3_r, {1'b0, p_r} <= q_r, "p above q")
  `HSL_ASSERT_NEXT(a_stage_advance, v3_r && en3, v4_r, "beat dropped between stage three and four")

endmodule

// ----- tb/sv/hsl_to_rgb_converter_tb.sv -----
// self-checking testbench for the hsl to rgb converter with random handshake idling
module hsl_to_rgb_converter_tb;
  import hsl_pkg::*;

  localparam int unsigned PIPE_LATENCY = 4;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned HUES_PER_PHASE = 125;
  localparam logic [REG_W-1:0] REG_MAX = {REG_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] IDX_MAX = {CFG_IDX_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED_IDX = CFG_LIGHT_IDX + 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [15:0]          in_hue = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  logic [REG_W-1:0] sat_shadow = SAT_RESET;
  logic [REG_W-1:0] light_shadow = LIGHT_RESET;

  logic [15:0]  hue_queue[$];
  rgb_t         rgb_expected[$];
  int unsigned  hues_queued = 0;
  int unsigned  hues_accepted = 0;
  int unsigned  in_gap = 0;
  int unsigned  out_wait = 0;
  bit           in_steady = 1'b0;
  bit           out_steady = 1'b0;
  int unsigned  mismatch_count = 0;

  logic [15:0] boundary_hues [14] = '{16'd0, 16'd1, 16'd10922, 16'd10923, 16'd21845,
                                      16'd21846, 16'd32767, 16'd32768, 16'd43690,
                                      16'd43691, 16'd54613, 16'd54614, 16'd65534,
                                      16'd65535};

  hsl_to_rgb_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_hue    (in_hue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] channel_from_q32(input logic [63:0] v);
    logic [63:0] c;
    c = (v * 64'd255) >> 32;
    return (c > 64'd255) ? 8'd255 : c[7:0];
  endfunction

  function automatic logic [7:0] hue_ramp(input logic [63:0] p, input logic [63:0] q,
                                          input logic [31:0] t6);
    logic [63:0] v;
    if (t6 < 32'(SIXTH6)) begin
      v = (p << 16) + (q - p) * 64'(t6);
    end else if (t6 < 32'(HALF_TURN6)) begin
      v = q << 16;
    end else if (t6 < 32'(TWO_THIRDS6)) begin
      v = (p << 16) + (q - p) * 64'(32'(TWO_THIRDS6) - t6);
    end else begin
      v = p << 16;
    end
    return channel_from_q32(v);
  endfunction

  function automatic rgb_t predict_rgb(input logic [15:0] hue, input logic [REG_W-1:0] sat_r,
                                       input logic [REG_W-1:0] light_r);
    logic [63:0] s;
    logic [63:0] l;
    logic [63:0] q;
    logic [63:0] p;
    logic [31:0] h6;
    rgb_t        c;
    s = (sat_r > Q_ONE) ? 64'(Q_ONE) : 64'(sat_r);
    l = (light_r > Q_ONE) ? 64'(Q_ONE) : 64'(light_r);
    h6 = 32'(hue) * 32'd6;
    if (s == 64'd0) begin
      c.red = channel_from_q32(l << 16);
      c.green = c.red;
      c.blue = c.red;
      return c;
    end
    if (l < 64'(HALF_Q)) begin
      q = (l * (64'(Q_ONE) + s)) >> 16;
    end else begin
      q = l + s - ((l * s) >> 16);
    end
    if (q > 64'd2 * l) begin
      q = 64'd2 * l;
    end
    if (q < l) begin
      q = l;
    end
    p = 64'd2 * l - q;
    c.red = hue_ramp(p, q, (h6 + 32'(THIRD6)) % 32'(TURN6));
    c.green = hue_ramp(p, q, h6);
    c.blue = hue_ramp(p, q, (h6 + 32'(TURN6) - 32'(THIRD6)) % 32'(TURN6));
    return c;
  endfunction

  function automatic logic [REG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return Q_ONE;
      2: return REG_MAX;
      3: return REG_W'($urandom_range(int'(Q_ONE) + 1, int'(REG_MAX)));
      default: return REG_W'($urandom_range(0, int'(Q_ONE)));
    endcase
  endfunction

  task automatic check_channel(input string name, input logic [7:0] expected_v,
                               input logic [7:0] actual_v);
    if (expected_v !== actual_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected_v, actual_v);
      mismatch_count++;
    end
  endtask

  task automatic queue_hue(input logic [15:0] hue);
    hue_queue.push_back(hue);
    hues_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SAT_IDX) begin
      sat_shadow <= data;
    end else if (idx == CFG_LIGHT_IDX) begin
      light_shadow <= data;
    end
  endtask

  task automatic set_color(input logic [REG_W-1:0] sat, input logic [REG_W-1:0] light);
    write_reg(CFG_SAT_IDX, sat);
    write_reg(CFG_LIGHT_IDX, light);
  endtask

  task automatic drain_pipeline();
    do @(posedge clk); while (hues_accepted != hues_queued || rgb_expected.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_hues
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        rgb_expected.push_back(predict_rgb(in_hue, sat_shadow, light_shadow));
        hues_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (hue_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_hue <= hue_queue.pop_front();
          in_gap <= in_steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_rgb
    rgb_t        exp_rgb;
    int unsigned stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else if (out_valid && out_ready) begin
      if (rgb_expected.size() == 0) begin
        $error("rgb beat with no hue pending: red %0d green %0d blue %0d",
               out_red, out_green, out_blue);
        mismatch_count++;
      end else begin
        exp_rgb = rgb_expected.pop_front();
        check_channel("red", exp_rgb.red, out_red);
        check_channel("green", exp_rgb.green, out_green);
        check_channel("blue", exp_rgb.blue, out_blue);
      end
      stall = out_steady ? 0 : $urandom_range(0, 3);
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_wait <= stall - 1;
      end
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // hue sector boundaries at the reset color
    foreach (boundary_hues[i]) begin
      queue_hue(boundary_hues[i]);
    end
    drain_pipeline();

    // zero saturation, gray output
    set_color('0, LIGHT_RESET);
    queue_hue(16'd0);
    queue_hue(16'd21846);
    drain_pipeline();

    // lightness above full scale with zero saturation
    write_reg(CFG_LIGHT_IDX, REG_MAX);
    queue_hue(16'd12345);
    drain_pipeline();

    // saturation above full scale
    set_color(REG_MAX, Q_ONE);
    queue_hue(16'd5000);
    drain_pipeline();

    set_color(Q_ONE, '0);
    queue_hue(16'd40000);
    drain_pipeline();

    // dark branch of q
    write_reg(CFG_LIGHT_IDX, HALF_Q - 1'b1);
    queue_hue(16'd30000);
    drain_pipeline();

    // writes to unused indexes leave the color alone
    write_reg(CFG_FIRST_UNUSED_IDX, '0);
    write_reg(IDX_MAX, REG_MAX);
    queue_hue(16'd7000);
    queue_hue(16'd60000);
    drain_pipeline();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_FIRST_UNUSED_IDX), int'(IDX_MAX))),
                  REG_W'($urandom));
      end
      if ($urandom_range(0, 1) == 0) begin
        set_color(pick_reg_value(), pick_reg_value());
      end else begin
        write_reg(CFG_LIGHT_IDX, pick_reg_value());
        write_reg(CFG_SAT_IDX, pick_reg_value());
      end
      in_steady = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < HUES_PER_PHASE; n++) begin
        queue_hue(16'($urandom_range(0, 65535)));
      end
      drain_pipeline();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/hsl_pkg.sv
design/hsl_cfg.sv
design/hsl_chan.sv
design/hsl_to_rgb_converter.sv
tb/sv/hsl_to_rgb_converter_tb.sv
